@@ hdl/mfc_pkg.sv @@
// Shared constants, types and the masked window sum for the 3x3 multi-filter block.
package mfc_pkg;

  localparam int MAX_WIDTH = 2048;
  localparam int COL_W     = $clog2(MAX_WIDTH);
  localparam int PIX_W     = 8;
  localparam int WIDTH_W   = 12;
  localparam int HEIGHT_W  = 16;
  localparam int MASK_W    = 9;
  localparam int NUM_FILT  = 6;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 16;

  typedef logic [PIX_W-1:0]  pixel_t;
  typedef logic [MASK_W-1:0] mask_t;
  typedef logic [COL_W-1:0]  col_t;
  typedef logic [HEIGHT_W-1:0] row_t;

  // Window pixels, entry index row*3+column, row 0 oldest.
  typedef logic [8:0][PIX_W-1:0] window_t;

  // Line store entry: two rows above in the high byte, row above in the low byte.
  typedef struct packed {
    pixel_t two_above;
    pixel_t one_above;
  } line_entry_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IMAGE_WIDTH        = 3'd0,
    CFG_IMAGE_HEIGHT       = 3'd1,
    CFG_MASK_VERTICAL      = 3'd2,
    CFG_MASK_HORIZONTAL    = 3'd3,
    CFG_MASK_ANTI_DIAGONAL = 3'd4,
    CFG_MASK_DIAGONAL      = 3'd5,
    CFG_MASK_CROSS_X       = 3'd6,
    CFG_MASK_DIAMOND       = 3'd7
  } cfg_index_t;

  localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = 12'd640;
  localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = 16'd480;
  localparam logic [WIDTH_W-1:0]  WIDTH_MIN    = 12'd3;
  localparam logic [WIDTH_W-1:0]  WIDTH_MAX    = WIDTH_W'(MAX_WIDTH);
  localparam logic [HEIGHT_W-1:0] HEIGHT_MIN   = 16'd3;

  localparam mask_t MASK_RESET [NUM_FILT] = '{
    9'd146, 9'd56, 9'd84, 9'd273, 9'd341, 9'd170
  };

  // Sum of the selected window pixels, wrapping modulo 256.
  function automatic pixel_t masked_sum(input mask_t mask, input window_t win);
    pixel_t acc;
    acc = '0;
    for (int i = 0; i < 9; i++) begin
      if (mask[i]) acc = acc + win[i];
    end
    return acc;
  endfunction

endpackage

@@ hdl/mfc_if.sv @@
// Channel interfaces for pixel input, filter results and register writes.
interface mfc_in_if import mfc_pkg::*; ();
  logic   valid;
  logic   ready;
  pixel_t pixel;
  logic   frame_start;

  modport source (output valid, pixel, frame_start, input ready);
  modport sink   (input valid, pixel, frame_start, output ready);
endinterface

interface mfc_out_if import mfc_pkg::*; ();
  logic   valid;
  logic   ready;
  pixel_t sum_f0;
  pixel_t sum_f1;
  pixel_t sum_f2;
  pixel_t sum_f3;
  pixel_t sum_f4;
  pixel_t sum_f5;
  logic   frame_last;

  modport source (output valid, sum_f0, sum_f1, sum_f2, sum_f3, sum_f4, sum_f5,
                  frame_last, input ready);
  modport sink   (input valid, sum_f0, sum_f1, sum_f2, sum_f3, sum_f4, sum_f5,
                  frame_last, output ready);
endinterface

interface mfc_cfg_if import mfc_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_DAT_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

@@ hdl/multi_filter_conv3x3_unit.sv @@
// Top level of the 3x3 multi-filter convolution unit.
// Pixels enter in raster order at one item per clock unless the output stalls; each
// pixel at row and column of at least 2 gives one result of six masked window sums
// (modulo 256), via stage 1 (line-store read) and the output register (window adds).
// The line stores need no clearing after reset. The user must write registers
// through the cfg channel only while the unit is idle; the block does not enforce this.
module multi_filter_conv3x3_unit
  import mfc_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  mfc_in_if.sink    in_ch,
  mfc_out_if.source out_ch,
  mfc_cfg_if.sink   cfg_ch
);

  // Configuration registers.
  logic [WIDTH_W-1:0]  width_r;
  logic [HEIGHT_W-1:0] height_r;
  mask_t               masks_r [NUM_FILT];

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WIDTH_RESET;
      height_r <= HEIGHT_RESET;
      for (int i = 0; i < NUM_FILT; i++) masks_r[i] <= MASK_RESET[i];
    end else if (cfg_ch.valid) begin
      case (cfg_index_t'(cfg_ch.index))
        CFG_IMAGE_WIDTH:        width_r    <= cfg_ch.data[WIDTH_W-1:0];
        CFG_IMAGE_HEIGHT:       height_r   <= cfg_ch.data[HEIGHT_W-1:0];
        CFG_MASK_VERTICAL:      masks_r[0] <= cfg_ch.data[MASK_W-1:0];
        CFG_MASK_HORIZONTAL:    masks_r[1] <= cfg_ch.data[MASK_W-1:0];
        CFG_MASK_ANTI_DIAGONAL: masks_r[2] <= cfg_ch.data[MASK_W-1:0];
        CFG_MASK_DIAGONAL:      masks_r[3] <= cfg_ch.data[MASK_W-1:0];
        CFG_MASK_CROSS_X:       masks_r[4] <= cfg_ch.data[MASK_W-1:0];
        CFG_MASK_DIAMOND:       masks_r[5] <= cfg_ch.data[MASK_W-1:0];
        default: ;
      endcase
    end
  end

  logic [WIDTH_W-1:0]  w_eff;
  logic [HEIGHT_W-1:0] h_eff;

  always_comb begin
    if (width_r < WIDTH_MIN)      w_eff = WIDTH_MIN;
    else if (width_r > WIDTH_MAX) w_eff = WIDTH_MAX;
    else                          w_eff = width_r;
    h_eff = (height_r < HEIGHT_MIN) ? HEIGHT_MIN : height_r;
  end

  // Position tracking at accept time.
  col_t   col_r, col_nxt, col_cur;
  row_t   row_r, row_nxt, row_cur;
  logic   emit_cur, last_cur;
  logic   in_fire;

  always_comb begin
    col_cur  = in_ch.frame_start ? '0 : col_r;
    row_cur  = in_ch.frame_start ? '0 : row_r;
    emit_cur = (row_cur >= HEIGHT_W'(2)) && (col_cur >= COL_W'(2));
    last_cur = (row_cur == h_eff - 16'd1) &&
               ({1'b0, col_cur} == WIDTH_W'(w_eff - 12'd1));
    if (({1'b0, col_cur} + 12'd1) >= w_eff) begin
      col_nxt = '0;
      row_nxt = (({1'b0, row_cur} + 17'd1) >= {1'b0, h_eff}) ? '0 : row_cur + 16'd1;
    end else begin
      col_nxt = col_cur + COL_W'(1);
      row_nxt = row_cur;
    end
  end

  // Stage 1 holds an item while its line-store read completes.
  logic   s1_valid_r;
  pixel_t s1_pixel_r;
  col_t   s1_col_r;
  logic   s1_emit_r;
  logic   s1_last_r;
  logic   s1_fire;
  logic   out_valid_r;

  assign s1_fire     = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !s1_valid_r || s1_fire;
  assign in_fire     = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r      <= '0;
      row_r      <= '0;
      s1_valid_r <= 1'b0;
    end else begin
      if (in_fire) begin
        col_r <= col_nxt;
        row_r <= row_nxt;
      end
      if (in_fire)      s1_valid_r <= 1'b1;
      else if (s1_fire) s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_pixel_r <= in_ch.pixel;
      s1_col_r   <= col_cur;
      s1_emit_r  <= emit_cur;
      s1_last_r  <= last_cur;
    end
  end

  line_entry_t line_rd;
  line_entry_t line_wr;

  assign line_wr.two_above = line_rd.one_above;
  assign line_wr.one_above = s1_pixel_r;

  mfc_linebuf u_linebuf (
    .clk     (clk),
    .rd_en   (in_fire),
    .rd_addr (col_cur),
    .rd_data (line_rd),
    .wr_en   (s1_fire),
    .wr_addr (s1_col_r),
    .wr_data (line_wr)
  );

  // Left two columns of the window: [row*2 + k], k = 0 oldest column.
  pixel_t  win_regs_r [6];
  window_t win;

  always_comb begin
    win[0] = win_regs_r[0];
    win[1] = win_regs_r[1];
    win[2] = line_rd.two_above;
    win[3] = win_regs_r[2];
    win[4] = win_regs_r[3];
    win[5] = line_rd.one_above;
    win[6] = win_regs_r[4];
    win[7] = win_regs_r[5];
    win[8] = s1_pixel_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 6; i++) win_regs_r[i] <= '0;
    end else if (s1_fire) begin
      win_regs_r[0] <= win[1];
      win_regs_r[1] <= win[2];
      win_regs_r[2] <= win[4];
      win_regs_r[3] <= win[5];
      win_regs_r[4] <= win[7];
      win_regs_r[5] <= win[8];
    end
  end

  // Output register.
  pixel_t sums_r [NUM_FILT];
  logic   last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_fire) begin
      out_valid_r <= s1_emit_r;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && s1_emit_r) begin
      for (int k = 0; k < NUM_FILT; k++) sums_r[k] <= masked_sum(masks_r[k], win);
      last_r <= s1_last_r;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.sum_f0     = sums_r[0];
  assign out_ch.sum_f1     = sums_r[1];
  assign out_ch.sum_f2     = sums_r[2];
  assign out_ch.sum_f3     = sums_r[3];
  assign out_ch.sum_f4     = sums_r[4];
  assign out_ch.sum_f5     = sums_r[5];
  assign out_ch.frame_last = last_r;

endmodule

@@ hdl/mfc_linebuf.sv @@
// Two-row line store in one synchronous memory with same-address write forwarding.
module mfc_linebuf
  import mfc_pkg::*;
(
  input  logic        clk,
  input  logic        rd_en,
  input  col_t        rd_addr,
  output line_entry_t rd_data,
  input  logic        wr_en,
  input  col_t        wr_addr,
  input  line_entry_t wr_data
);

  line_entry_t mem [MAX_WIDTH];
  line_entry_t rd_data_r;
  line_entry_t fwd_data_r;
  logic        fwd_r;

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
  end

  // A read that lands on the entry being written in the same cycle takes the new data.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r  <= mem[rd_addr];
      fwd_r      <= wr_en && (wr_addr == rd_addr);
      fwd_data_r <= wr_data;
    end
  end

  assign rd_data = fwd_r ? fwd_data_r : rd_data_r;

endmodule

@@ tb/tb_top.sv @@
// Self-checking testbench for the 3x3 multi-filter convolution unit.
module tb_top
  import mfc_pkg::*;
();

  localparam int unsigned CYCLE_LIMIT  = 3_000_000;
  localparam int unsigned PIPE_SETTLE  = 4;
  localparam int unsigned DRAIN_LIMIT  = 200_000;
  localparam int unsigned RANDOM_ITEMS = 450;

  typedef struct packed {
    logic [NUM_FILT-1:0][PIX_W-1:0] sums;
    logic                           last;
  } filter_sums_t;

  logic clk = 1'b0;
  logic rst_n;

  mfc_in_if  in_if ();
  mfc_out_if out_if ();
  mfc_cfg_if cfg_if ();

  multi_filter_conv3x3_unit i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if),
    .cfg_ch (cfg_if)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow of the block: registers, line stores, window columns, position.
  logic [WIDTH_W-1:0]  width_reg  = WIDTH_RESET;
  logic [HEIGHT_W-1:0] height_reg = HEIGHT_RESET;
  mask_t               filt_mask [NUM_FILT] = MASK_RESET;
  pixel_t              row_above [MAX_WIDTH] = '{default: '0};
  pixel_t              two_above [MAX_WIDTH] = '{default: '0};
  pixel_t              win_cols [6] = '{default: '0};
  int unsigned         col_pos = 0;
  int unsigned         row_pos = 0;

  filter_sums_t filter_sums_q [$];
  filter_sums_t got_sums;
  filter_sums_t want_sums;

  int unsigned mismatch_cnt = 0;
  int unsigned pixels_sent  = 0;
  int unsigned sums_checked = 0;
  int unsigned reg_writes   = 0;
  int unsigned cycle_cnt    = 0;
  int unsigned stall_left   = 0;
  bit          tx_gaps_on   = 1'b1;
  bit          rx_stalls_on = 1'b1;

  function automatic int unsigned eff_cols(input logic [WIDTH_W-1:0] w);
    if (w < WIDTH_MIN) return 32'(WIDTH_MIN);
    if (w > WIDTH_MAX) return 32'(WIDTH_MAX);
    return 32'(w);
  endfunction

  function automatic int unsigned eff_rows(input logic [HEIGHT_W-1:0] h);
    return (h < HEIGHT_MIN) ? 32'(HEIGHT_MIN) : 32'(h);
  endfunction

  // Mostly zero, sometimes a short pause, now and then a long one.
  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  function automatic pixel_t rand_pixel();
    if ($urandom_range(0, 4) == 0) return $urandom_range(0, 1) ? 8'hFF : 8'h00;
    return 8'($urandom_range(0, 255));
  endfunction

  // Advances the shadow by one pixel; returns 1 when the pixel completes a window.
  function automatic bit predict_window_sums(input pixel_t px, input logic fs,
                                             output filter_sums_t res);
    int unsigned ew, eh, c, r, idx;
    pixel_t      win [9];
    pixel_t      acc;
    bit          full;
    ew = eff_cols(width_reg);
    eh = eff_rows(height_reg);
    if (fs) begin
      col_pos = 0;
      row_pos = 0;
    end
    c   = col_pos;
    r   = row_pos;
    idx = c % MAX_WIDTH;
    win[0] = win_cols[0]; win[1] = win_cols[1]; win[2] = two_above[idx];
    win[3] = win_cols[2]; win[4] = win_cols[3]; win[5] = row_above[idx];
    win[6] = win_cols[4]; win[7] = win_cols[5]; win[8] = px;
    full = (r >= 2) && (c >= 2);
    res = '0;
    if (full) begin
      for (int k = 0; k < NUM_FILT; k++) begin
        acc = '0;
        for (int b = 0; b < 9; b++) if (filt_mask[k][b]) acc = acc + win[b];
        res.sums[k] = acc;
      end
      res.last = (r == eh - 1) && (c == ew - 1);
    end
    win_cols[0] = win[1]; win_cols[1] = win[2];
    win_cols[2] = win[4]; win_cols[3] = win[5];
    win_cols[4] = win[7]; win_cols[5] = win[8];
    two_above[idx] = win[5];
    row_above[idx] = px;
    if (c + 1 >= ew) begin
      col_pos = 0;
      row_pos = (r + 1 >= eh) ? 0 : r + 1;
    end else begin
      col_pos = c + 1;
    end
    return full;
  endfunction

  // Sends one pixel and records the window sums it should produce.
  task automatic push_pixel(input pixel_t px, input logic fs);
    int unsigned  gap;
    filter_sums_t res;
    gap = tx_gaps_on ? idle_len() : 0;
    if (gap > 0) begin
      in_if.valid       <= 1'b0;
      in_if.pixel       <= 8'($urandom);
      in_if.frame_start <= 1'($urandom);
      repeat (gap) @(posedge clk);
    end
    in_if.valid       <= 1'b1;
    in_if.pixel       <= px;
    in_if.frame_start <= fs;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    pixels_sent++;
    if (predict_window_sums(px, fs, res)) filter_sums_q = {filter_sums_q, res};
  endtask

  // Leaves cfg valid high so that back-to-back writes need no extra toggle.
  task automatic write_reg(input cfg_index_t idx, input logic [CFG_DAT_W-1:0] val);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    reg_writes++;
    case (idx)
      CFG_IMAGE_WIDTH: width_reg = val[WIDTH_W-1:0];
      CFG_IMAGE_HEIGHT: height_reg = val;
      default: filt_mask[idx - CFG_MASK_VERTICAL] = val[MASK_W-1:0];
    endcase
  endtask

  // Unused upper data bits are filled at random; the block must ignore them.
  task automatic program_regs(input logic [WIDTH_W-1:0] w, input logic [HEIGHT_W-1:0] h,
                              input logic [NUM_FILT-1:0][MASK_W-1:0] m);
    write_reg(CFG_IMAGE_WIDTH, {4'($urandom), w});
    write_reg(CFG_IMAGE_HEIGHT, h);
    for (int k = 0; k < NUM_FILT; k++)
      write_reg(cfg_index_t'(CFG_MASK_VERTICAL + k), {7'($urandom), m[k]});
    cfg_if.valid <= 1'b0;
  endtask

  task automatic wait_idle();
    in_if.valid <= 1'b0;
    while (filter_sums_q.size() != 0) @(posedge clk);
    repeat (PIPE_SETTLE) @(posedge clk);
  endtask

  function automatic logic [NUM_FILT-1:0][MASK_W-1:0] rand_masks();
    logic [NUM_FILT-1:0][MASK_W-1:0] m;
    int unsigned r;
    for (int k = 0; k < NUM_FILT; k++) begin
      r = $urandom_range(0, 99);
      m[k] = (r < 12) ? 9'd0 : (r < 24) ? 9'h1FF : 9'($urandom);
    end
    return m;
  endfunction

  // Masks as they come out of reset, on a small frame that wraps into the next.
  task automatic test_reset_defaults();
    write_reg(CFG_IMAGE_WIDTH, 16'd6);
    write_reg(CFG_IMAGE_HEIGHT, 16'd4);
    cfg_if.valid <= 1'b0;
    push_pixel(rand_pixel(), 1'b1);
    for (int i = 1; i < 6 * 4 + 2; i++) push_pixel(rand_pixel(), 1'b0);
    wait_idle();
  endtask

  // Clamped sizes, all-ones and empty masks, wrap of the sums, resync and self wrap.
  task automatic test_small_frames();
    logic [NUM_FILT-1:0][MASK_W-1:0] m;
    m[0] = 9'h1FF; m[1] = 9'd0;   m[2] = 9'd1;
    m[3] = 9'h100; m[4] = 9'd341; m[5] = 9'd170;
    program_regs(12'd1, 16'd0, m);
    for (int i = 0; i < 9; i++) push_pixel(8'hFF, i == 0);
    for (int i = 0; i < 4; i++) push_pixel(8'h00, i == 0);
    for (int i = 0; i < 9; i++) push_pixel((i % 2) ? 8'hFF : 8'h5A + 8'(i), i == 0);
    for (int i = 0; i < 3; i++) push_pixel(8'hA5, 1'b0);
    wait_idle();
  endtask

  // Width and height lowered while the position lies beyond the new limits.
  task automatic test_shrink_mid_frame();
    program_regs(12'd8, 16'd8, rand_masks());
    for (int i = 0; i < 4 * 8 + 5; i++) push_pixel(rand_pixel(), i == 0);
    wait_idle();
    program_regs(12'd4, 16'd3, rand_masks());
    for (int i = 0; i < 20; i++) push_pixel(rand_pixel(), 1'b0);
    wait_idle();
    program_regs(12'd8, 16'd8, rand_masks());
    for (int i = 0; i < 5 * 8 + 2; i++) push_pixel(rand_pixel(), i == 0);
    wait_idle();
    program_regs(12'd8, 16'd4, rand_masks());
    for (int i = 0; i < 6 + 32; i++) push_pixel(rand_pixel(), 1'b0);
    wait_idle();
  endtask

  // Full-scale height: the row counter runs far on without reaching a frame end.
  task automatic test_tallest_frame();
    program_regs(12'd3, 16'hFFFF, rand_masks());
    for (int i = 0; i < 3 * 100; i++) push_pixel(rand_pixel(), i == 0);
    wait_idle();
  endtask

  // Random settings and mostly whole frames, with cut frames and stray frame starts.
  task automatic test_random_frames();
    logic [WIDTH_W-1:0]  w;
    logic [HEIGHT_W-1:0] h;
    int unsigned         r, ew, n_frames, fr_len, cut, sent;
    bit                  need_fs, fs;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      r = $urandom_range(0, 99);
      w = (r < 8) ? 12'($urandom_range(0, 2)) : (r < 12) ? 12'($urandom_range(13, 40))
                                                         : 12'($urandom_range(3, 12));
      r = $urandom_range(0, 99);
      if (w > 12) h = 16'($urandom_range(3, 4));
      else h = (r < 8) ? 16'($urandom_range(0, 2)) : (r < 12) ? 16'($urandom_range(8, 20))
                                                              : 16'($urandom_range(3, 7));
      // A wider line must start a new frame so that no unwritten entry is read.
      need_fs = eff_cols(w) > eff_cols(width_reg);
      wait_idle();
      program_regs(w, h, rand_masks());
      tx_gaps_on   = $urandom_range(0, 3) != 0;
      rx_stalls_on = $urandom_range(0, 3) != 0;
      ew       = eff_cols(w);
      fr_len   = ew * eff_rows(h);
      n_frames = $urandom_range(1, 3);
      for (int f = 0; f < n_frames; f++) begin
        cut = ($urandom_range(0, 9) == 0) ? $urandom_range(1, fr_len) : fr_len;
        for (int i = 0; i < cut; i++) begin
          if (i == 0) fs = (f == 0 && need_fs) || ($urandom_range(0, 4) != 0);
          else fs = ($urandom_range(0, 99) == 0);
          push_pixel(rand_pixel(), fs);
          sent++;
        end
      end
    end
    tx_gaps_on   = 1'b1;
    rx_stalls_on = 1'b1;
  endtask

  always @(posedge clk) begin
    if (!rx_stalls_on) begin
      out_if.ready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_if.ready <= 1'b0;
    end else if ($urandom_range(0, 3) == 0) begin
      stall_left = idle_len();
      out_if.ready <= (stall_left == 0);
    end else begin
      out_if.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready) begin
      got_sums.sums = {out_if.sum_f5, out_if.sum_f4, out_if.sum_f3,
                       out_if.sum_f2, out_if.sum_f1, out_if.sum_f0};
      got_sums.last = out_if.frame_last;
      if (filter_sums_q.size() == 0) begin
        $error("result with no pixel window pending: sums %h frame_last %0b",
               got_sums.sums, got_sums.last);
        mismatch_cnt++;
      end else begin
        want_sums = filter_sums_q.pop_front();
        sums_checked++;
        for (int k = 0; k < NUM_FILT; k++) begin
          if (got_sums.sums[k] !== want_sums.sums[k]) begin
            $error("sum_f%0d expected %0d got %0d", k, want_sums.sums[k], got_sums.sums[k]);
            mismatch_cnt++;
          end
        end
        if (got_sums.last !== want_sums.last) begin
          $error("frame_last expected %0b got %0b", want_sums.last, got_sums.last);
          mismatch_cnt++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d windows outstanding",
               cycle_cnt, filter_sums_q.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    int unsigned waited;
    rst_n             <= 1'b0;
    in_if.valid       <= 1'b0;
    in_if.pixel       <= '0;
    in_if.frame_start <= 1'b0;
    cfg_if.valid      <= 1'b0;
    cfg_if.index      <= CFG_IMAGE_WIDTH;
    cfg_if.data       <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_defaults();
    test_small_frames();
    test_shrink_mid_frame();
    test_tallest_frame();
    test_random_frames();

    in_if.valid <= 1'b0;
    waited = 0;
    while (filter_sums_q.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (PIPE_SETTLE * 2) @(posedge clk);
    if (filter_sums_q.size() != 0) begin
      $error("%0d expected windows never came out", filter_sums_q.size());
      mismatch_cnt++;
    end

    $display("Ran %0d pixels through %0d register writes; %0d window results compared.",
             pixels_sent, reg_writes, sums_checked);
    $display("Covered reset masks, clamped sizes, mid-frame shrink, a tall frame "
             , "and random frames.");
    if (mismatch_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
